// File: hw/rtl/glpd_pkg.sv
// ----------------------------------------------------------------------------
// glpd_pkg
// Shared constants and types of the grid local peak detector.
// ----------------------------------------------------------------------------
`default_nettype none

package glpd_pkg;

  // default parameter values
  localparam int unsigned MaxColsDef    = 1024;
  localparam int unsigned SampleBitsDef = 16;

  // fixed field widths
  localparam int unsigned RowW = 10;
  localparam int unsigned ColW = 10;
  localparam int unsigned CfgW = 11;

  // configuration port
  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;
  localparam int unsigned RegSelBit = 2;

  // register limits and reset values
  localparam int unsigned RowLimit = 1024;
  localparam int unsigned DimLimit = 1024;
  localparam logic [CfgW-1:0] CfgReset = CfgW'(1024);

  typedef enum logic {
    RegRows = 1'b0,
    RegCols = 1'b1
  } reg_idx_e;

  // result slots of one item: position above, position to the left, the item itself
  localparam int unsigned SlotAbove = 0;
  localparam int unsigned SlotLeft  = 1;
  localparam int unsigned SlotSelf  = 2;
  localparam int unsigned NumSlots  = 3;

  typedef struct packed {
    logic [NumSlots-1:0] mask;
    logic [RowW-1:0]     row;
    logic [ColW-1:0]     col;
  } grp_ctl_t;

endpackage

`default_nettype wire

// File: hw/rtl/grid_local_peak_detector.sv
// ----------------------------------------------------------------------------
// grid_local_peak_detector
// Finds 4-neighbour local maxima in a raster-order grid of signed samples.
// ----------------------------------------------------------------------------
// Samples enter on the input channel (in_valid_i / in_stall_o), one per item,
// row by row. Each peak leaves as one output item (out_valid_o / out_stall_i)
// with its row, column and value; last_of_run_o marks the last peak caused
// by one input item. The position above a new sample is decided with that
// sample; in the last row the position to its left and, on the final sample,
// the sample itself are decided as well, so one item yields up to 3 peaks.
// Each item's peaks are pushed to the result queue when it is accepted.
// Throughput: one input item per cycle unless in_stall_o is high; the line
// store is a two-read-port RAM holding both stored rows of a column in one
// word, read ahead at the next column and written back in the accept cycle.
// The output side sends one peak per cycle unless stalled, one output item
// per peak. A two-group result queue parts the two sides; when the receiver
// stalls, up to two items' peaks are held and then in_stall_o goes high.
// Reset sets the raster position to the origin and both size registers to
// 1024. The line store is not cleared; each frame writes it before use.
// Sizes are set through the APB port: rows at 0x0, columns at 0x4.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_local_peak_detector #(
  parameter int unsigned MAX_COLS    = glpd_pkg::MaxColsDef,
  parameter int unsigned SAMPLE_BITS = glpd_pkg::SampleBitsDef
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // sample channel
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic signed [SAMPLE_BITS-1:0]     pixel_value_i,
  // peak channel
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic      [glpd_pkg::RowW-1:0]         peak_row_o,
  output logic      [glpd_pkg::ColW-1:0]         peak_col_o,
  output logic signed [SAMPLE_BITS-1:0]          peak_value_o,
  output logic                                   last_of_run_o,
  // configuration
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [glpd_pkg::ApbAddrW-1:0]     paddr,
  input  wire logic [glpd_pkg::ApbDataW-1:0]     pwdata,
  output logic      [glpd_pkg::ApbDataW-1:0]     prdata,
  output logic                                   pready
);

  localparam int unsigned ColAddrW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned ColLimit = (MAX_COLS < glpd_pkg::DimLimit) ?
                                     MAX_COLS : glpd_pkg::DimLimit;
  localparam int unsigned WordW    = 2 * SAMPLE_BITS;
  localparam int unsigned CfgW     = glpd_pkg::CfgW;
  localparam int unsigned RowW     = glpd_pkg::RowW;
  localparam int unsigned ColW     = glpd_pkg::ColW;

  localparam logic [CfgW-1:0] RowLimitCfg = CfgW'(glpd_pkg::RowLimit);
  localparam logic [CfgW-1:0] ColLimitCfg = CfgW'(ColLimit);
  localparam logic [RowW-1:0] RowLastMax  = RowW'(glpd_pkg::RowLimit - 1);
  localparam logic [ColW-1:0] ColLastMax  = ColW'(ColLimit - 1);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  function automatic logic nb_ge(sample_t cur, sample_t nb, logic has);
    return !has || (cur >= nb);
  endfunction

  function automatic logic nb_gt(sample_t cur, sample_t nb, logic has);
    return has && (cur > nb);
  endfunction

  // ---------------------------------------------------------------- config
  logic [CfgW-1:0] rows_cfg_q, cols_cfg_q;
  logic [RowW-1:0] row_last_q;
  logic [ColW-1:0] col_last_q;
  logic            cfg_wr;
  logic [CfgW-1:0] wval;
  glpd_pkg::reg_idx_e cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign wval    = pwdata[CfgW-1:0];
  assign cfg_sel = glpd_pkg::reg_idx_e'(paddr[glpd_pkg::RegSelBit]);

  always_comb begin
    case (cfg_sel)
      glpd_pkg::RegRows: prdata = glpd_pkg::ApbDataW'(rows_cfg_q);
      glpd_pkg::RegCols: prdata = glpd_pkg::ApbDataW'(cols_cfg_q);
      default:           prdata = '0;
    endcase
  end

  // keep the clamped last index next to each raw register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_cfg_q <= glpd_pkg::CfgReset;
      cols_cfg_q <= glpd_pkg::CfgReset;
      row_last_q <= RowLastMax;
      col_last_q <= ColLastMax;
    end else if (cfg_wr) begin
      case (cfg_sel)
        glpd_pkg::RegRows: begin
          rows_cfg_q <= wval;
          if (wval == '0) begin
            row_last_q <= '0;
          end else if (wval > RowLimitCfg) begin
            row_last_q <= RowLastMax;
          end else begin
            row_last_q <= RowW'(wval - CfgW'(1));
          end
        end
        glpd_pkg::RegCols: begin
          cols_cfg_q <= wval;
          if (wval == '0) begin
            col_last_q <= '0;
          end else if (wval > ColLimitCfg) begin
            col_last_q <= ColLastMax;
          end else begin
            col_last_q <= ColW'(wval - CfgW'(1));
          end
        end
        default: begin
        end
      endcase
    end
  end

  // -------------------------------------------------------------- raster
  logic            in_accept;
  logic [RowW-1:0] row_q, row_d;
  logic [ColW-1:0] col_q, col_d;
  logic            wrap, last_row;

  assign in_accept = in_valid_i & ~in_stall_o;
  assign wrap      = (col_q >= col_last_q);
  assign last_row  = (row_q >= row_last_q);

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (in_accept) begin
      if (wrap) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + RowW'(1);
      end else begin
        col_d = col_q + ColW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  // ---------------------------------------------------------- line store
  // one word per column: {odd row, even row}
  logic [ColAddrW-1:0] raddr_a, raddr_b, waddr;
  logic [WordW-1:0]    rdata_a, rdata_b, wdata;
  logic [WordW-1:0]    word_a, word_b;
  logic                fwd_a_q, fwd_b_q;
  logic [WordW-1:0]    fwd_data_q;

  assign raddr_a = ColAddrW'(col_d);
  assign raddr_b = raddr_a + ColAddrW'(1);
  assign waddr   = ColAddrW'(col_q);

  glpd_ram #(
    .WIDTH (WordW),
    .DEPTH (MAX_COLS)
  ) u_line_ram (
    .clk_i     (clk_i),
    .we_i      (in_accept),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (raddr_a),
    .rdata_a_o (rdata_a),
    .raddr_b_i (raddr_b),
    .rdata_b_o (rdata_b)
  );

  // the RAM returns old data on a same-address read; take the written word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_a_q <= 1'b0;
      fwd_b_q <= 1'b0;
    end else begin
      fwd_a_q <= in_accept && (waddr == raddr_a);
      fwd_b_q <= in_accept && (waddr == raddr_b);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      fwd_data_q <= wdata;
    end
  end

  assign word_a = fwd_a_q ? fwd_data_q : rdata_a;
  assign word_b = fwd_b_q ? fwd_data_q : rdata_b;

  sample_t v, above, upper, right;

  assign v     = pixel_value_i;
  // row R-1 and the older row R-2 of this column, row R-1 of the next one
  assign above = row_q[0] ? sample_t'(word_a[SAMPLE_BITS-1:0])
                          : sample_t'(word_a[WordW-1:SAMPLE_BITS]);
  assign upper = row_q[0] ? sample_t'(word_a[WordW-1:SAMPLE_BITS])
                          : sample_t'(word_a[SAMPLE_BITS-1:0]);
  assign right = row_q[0] ? sample_t'(word_b[SAMPLE_BITS-1:0])
                          : sample_t'(word_b[WordW-1:SAMPLE_BITS]);
  assign wdata = row_q[0] ? {v, above} : {above, v};

  // ------------------------------------------------------------- window
  sample_t prev_v_q, prev2_v_q, prev_above_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_v_q     <= '0;
      prev2_v_q    <= '0;
      prev_above_q <= '0;
    end else if (in_accept) begin
      prev2_v_q    <= prev_v_q;
      prev_v_q     <= v;
      prev_above_q <= above;
    end
  end

  // ---------------------------------------------------------- decisions
  logic has_r, has_r2, has_c, has_c2, has_right;
  logic pk_above, pk_left, pk_self;

  assign has_r     = (row_q != '0);
  assign has_r2    = (row_q > RowW'(1));
  assign has_c     = (col_q != '0);
  assign has_c2    = (col_q > ColW'(1));
  assign has_right = ~wrap;

  assign pk_above = has_r &&
    nb_ge(above, upper, has_r2) && nb_ge(above, v, 1'b1) &&
    nb_ge(above, prev_above_q, has_c) && nb_ge(above, right, has_right) &&
    (nb_gt(above, upper, has_r2) || nb_gt(above, v, 1'b1) ||
     nb_gt(above, prev_above_q, has_c) || nb_gt(above, right, has_right));

  assign pk_left = last_row && has_c &&
    nb_ge(prev_v_q, prev_above_q, has_r) && nb_ge(prev_v_q, prev2_v_q, has_c2) &&
    nb_ge(prev_v_q, v, 1'b1) &&
    (nb_gt(prev_v_q, prev_above_q, has_r) || nb_gt(prev_v_q, prev2_v_q, has_c2) ||
     nb_gt(prev_v_q, v, 1'b1));

  assign pk_self = last_row && wrap &&
    nb_ge(v, above, has_r) && nb_ge(v, prev_v_q, has_c) &&
    (nb_gt(v, above, has_r) || nb_gt(v, prev_v_q, has_c));

  glpd_pkg::grp_ctl_t grp_ctl;
  logic [glpd_pkg::NumSlots-1:0][SAMPLE_BITS-1:0] grp_val;
  logic grp_push;

  always_comb begin
    grp_ctl.mask                     = '0;
    grp_ctl.mask[glpd_pkg::SlotAbove] = pk_above;
    grp_ctl.mask[glpd_pkg::SlotLeft]  = pk_left;
    grp_ctl.mask[glpd_pkg::SlotSelf]  = pk_self;
    grp_ctl.row                      = row_q;
    grp_ctl.col                      = col_q;
    grp_val[glpd_pkg::SlotAbove]     = above;
    grp_val[glpd_pkg::SlotLeft]      = prev_v_q;
    grp_val[glpd_pkg::SlotSelf]      = v;
  end

  assign grp_push = in_accept & (grp_ctl.mask != '0);

  glpd_result_q #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_result_q (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (grp_push),
    .push_ctl_i    (grp_ctl),
    .push_val_i    (grp_val),
    .full_o        (in_stall_o),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .peak_row_o    (peak_row_o),
    .peak_col_o    (peak_col_o),
    .peak_value_o  (peak_value_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

`default_nettype wire

// File: hw/rtl/glpd_ram.sv
// ----------------------------------------------------------------------------
// glpd_ram
// Generic RAM: one write port, two read ports, registered read (old data on
// a read of the address being written).
// ----------------------------------------------------------------------------
`default_nettype none

module glpd_ram #(
  parameter  int unsigned WIDTH = 32,
  parameter  int unsigned DEPTH = 1024,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_a_i,
  output logic      [WIDTH-1:0] rdata_a_o,
  input  wire logic [AddrW-1:0] raddr_b_i,
  output logic      [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

`default_nettype wire

// File: hw/rtl/glpd_result_q.sv
// ----------------------------------------------------------------------------
// glpd_result_q
// Two-deep queue of result groups; hands out one peak per output item.
// ----------------------------------------------------------------------------
`default_nettype none

module glpd_result_q #(
  parameter int unsigned SAMPLE_BITS = glpd_pkg::SampleBitsDef
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      push_i,
  input  wire glpd_pkg::grp_ctl_t        push_ctl_i,
  input  wire logic [glpd_pkg::NumSlots-1:0][SAMPLE_BITS-1:0] push_val_i,
  output logic                           full_o,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output logic      [glpd_pkg::RowW-1:0] peak_row_o,
  output logic      [glpd_pkg::ColW-1:0] peak_col_o,
  output logic signed [SAMPLE_BITS-1:0]  peak_value_o,
  output logic                           last_of_run_o
);

  glpd_pkg::grp_ctl_t ctl_q [2];
  logic [glpd_pkg::NumSlots-1:0][SAMPLE_BITS-1:0] val_q [2];

  logic [1:0] cnt_q, cnt_d;
  logic       rd_ptr_q, wr_ptr_q;

  glpd_pkg::grp_ctl_t           head;
  logic [glpd_pkg::NumSlots-1:0] rest_mask;
  logic                          pop_slot, pop_grp;

  assign head        = ctl_q[rd_ptr_q];
  assign out_valid_o = (cnt_q != 2'd0);
  assign full_o      = (cnt_q == 2'd2);
  // drop the lowest pending slot
  assign rest_mask     = head.mask & (head.mask - glpd_pkg::NumSlots'(1));
  assign last_of_run_o = (rest_mask == '0);
  assign pop_slot      = out_valid_o & ~out_stall_i;
  assign pop_grp       = pop_slot & last_of_run_o;

  always_comb begin
    if (head.mask[glpd_pkg::SlotAbove]) begin
      peak_row_o   = head.row - glpd_pkg::RowW'(1);
      peak_col_o   = head.col;
      peak_value_o = $signed(val_q[rd_ptr_q][glpd_pkg::SlotAbove]);
    end else if (head.mask[glpd_pkg::SlotLeft]) begin
      peak_row_o   = head.row;
      peak_col_o   = head.col - glpd_pkg::ColW'(1);
      peak_value_o = $signed(val_q[rd_ptr_q][glpd_pkg::SlotLeft]);
    end else begin
      peak_row_o   = head.row;
      peak_col_o   = head.col;
      peak_value_o = $signed(val_q[rd_ptr_q][glpd_pkg::SlotSelf]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ctl_q[wr_ptr_q] <= push_ctl_i;
      val_q[wr_ptr_q] <= push_val_i;
    end
    if (pop_slot && !last_of_run_o) begin
      ctl_q[rd_ptr_q].mask <= rest_mask;
    end
  end

  assign cnt_d = cnt_q + 2'(push_i) - 2'(pop_grp);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= 2'd0;
      rd_ptr_q <= 1'b0;
      wr_ptr_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_grp) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/glpd_checker.sv
// ----------------------------------------------------------------------------
// glpd_checker
// Port-level checks of the grid local peak detector, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module glpd_checker #(
  parameter int unsigned SAMPLE_BITS = glpd_pkg::SampleBitsDef
) (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid_i,
  input wire logic                          in_stall_o,
  input wire logic [SAMPLE_BITS-1:0]        pixel_value_i,
  input wire logic                          out_valid_o,
  input wire logic                          out_stall_i,
  input wire logic [glpd_pkg::RowW-1:0]     peak_row_o,
  input wire logic [glpd_pkg::ColW-1:0]     peak_col_o,
  input wire logic [SAMPLE_BITS-1:0]        peak_value_o,
  input wire logic                          last_of_run_o,
  input wire logic                          psel,
  input wire logic                          penable,
  input wire logic                          pwrite,
  input wire logic [glpd_pkg::ApbAddrW-1:0] paddr,
  input wire logic [glpd_pkg::ApbDataW-1:0] pwdata,
  input wire logic [glpd_pkg::ApbDataW-1:0] prdata,
  input wire logic                          pready
);

  localparam int unsigned CfgW = glpd_pkg::CfgW;
  localparam int unsigned DataW = glpd_pkg::ApbDataW;

  // a stalled peak holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(peak_row_o) &&
      $stable(peak_col_o) && $stable(peak_value_o) && $stable(last_of_run_o))
    else $error("peak item changed while stalled");

  // a stalled sample holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(pixel_value_i))
    else $error("input item changed while stalled");

  // input backs up only behind held results
  a_stall_needs_results: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result pending");

  // the queue fills only while the head group is not leaving
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_valid_o && (out_stall_i || !last_of_run_o)))
    else $error("input stall rose while the head group was leaving");

  // a register reads back what was written, cut to its width
  a_cfg_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && pready) ##1
      (psel && !pwrite && paddr[glpd_pkg::RegSelBit] ==
       $past(paddr[glpd_pkg::RegSelBit]))
    |-> prdata[CfgW-1:0] == $past(pwdata[CfgW-1:0]) &&
        prdata[DataW-1:CfgW] == '0)
    else $error("register read back differs from last write");

endmodule

bind grid_local_peak_detector glpd_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_glpd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .pixel_value_i (pixel_value_i),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .peak_row_o    (peak_row_o),
  .peak_col_o    (peak_col_o),
  .peak_value_o  (peak_value_o),
  .last_of_run_o (last_of_run_o),
  .psel          (psel),
  .penable       (penable),
  .pwrite        (pwrite),
  .paddr         (paddr),
  .pwdata        (pwdata),
  .prdata        (prdata),
  .pready        (pready)
);

`default_nettype wire
